/* rtl/fdft_pkg.sv */
// Shared constants, handshake structs and DFT weight tables for the fundamental RMS meter.
`timescale 1ns / 1ps

package fdft_pkg;

    localparam int WINDOW_LENGTH = 24;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int TAP_W         = 5;
    localparam int WEIGHT_W      = 18;
    localparam int RMS_W         = 24;

    localparam logic [RMS_W-1:0] RMS_MAX = '1;

    // 3072 = 3 << 10: bias and shift for the rounded scaling, then a divide by three
    localparam int ROUND_BIAS  = 1536;
    localparam int ROUND_SHIFT = 10;

    // final scaling: (mag * 2^16 + KBIAS) / KDIV, KDIV = round(1.414 * 2^16)
    localparam int               KDIV_W = 17;
    localparam logic [KDIV_W-1:0] KDIV  = 17'd92668;
    localparam logic [15:0]       KBIAS = 16'd46334;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] rms;
    } lane_status_t;

    // Q16 cosine of 15k degrees
    function automatic logic signed [WEIGHT_W-1:0] cos_weight(input logic [TAP_W-1:0] k);
        logic signed [WEIGHT_W-1:0] w;
        case (k)
            5'd0:    w = 18'sd65536;
            5'd1:    w = 18'sd63303;
            5'd2:    w = 18'sd56754;
            5'd3:    w = 18'sd46341;
            5'd4:    w = 18'sd32768;
            5'd5:    w = 18'sd16962;
            5'd6:    w = 18'sd0;
            5'd7:    w = -18'sd16962;
            5'd8:    w = -18'sd32768;
            5'd9:    w = -18'sd46341;
            5'd10:   w = -18'sd56754;
            5'd11:   w = -18'sd63303;
            5'd12:   w = -18'sd65536;
            5'd13:   w = -18'sd63303;
            5'd14:   w = -18'sd56754;
            5'd15:   w = -18'sd46341;
            5'd16:   w = -18'sd32768;
            5'd17:   w = -18'sd16962;
            5'd18:   w = 18'sd0;
            5'd19:   w = 18'sd16962;
            5'd20:   w = 18'sd32768;
            5'd21:   w = 18'sd46341;
            5'd22:   w = 18'sd56754;
            5'd23:   w = 18'sd63303;
            default: w = 18'sd0;
        endcase
        return w;
    endfunction

    // Q16 sine of 15k degrees, taken from the cosine table a quarter turn back
    function automatic logic signed [WEIGHT_W-1:0] sin_weight(input logic [TAP_W-1:0] k);
        logic [TAP_W-1:0] j;
        j = (k >= 5'd6) ? k - 5'd6 : k + 5'd18;
        return cos_weight(j);
    endfunction

endpackage

/* rtl/fdft_stream_if.sv */
// Valid/ready stream interfaces for the sample pair and the RMS result pair.
`timescale 1ns / 1ps

interface fdft_in_if #(
    parameter int SAMPLE_WIDTH = fdft_pkg::SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] chan0_sample;
    logic signed [SAMPLE_WIDTH-1:0] chan1_sample;

    modport source (output valid, output chan0_sample, output chan1_sample, input ready);
    modport sink   (input valid, input chan0_sample, input chan1_sample, output ready);
endinterface

interface fdft_out_if ();
    logic                        valid;
    logic                        ready;
    logic [fdft_pkg::RMS_W-1:0]  chan0_rms;
    logic [fdft_pkg::RMS_W-1:0]  chan1_rms;

    modport source (output valid, output chan0_rms, output chan1_rms, input ready);
    modport sink   (input valid, input chan0_rms, input chan1_rms, output ready);
endinterface

/* rtl/fdft_lane.sv */
// One channel lane: sample window, serial DFT tap walk, divide by three, square root, scaling.
`timescale 1ns / 1ps

module fdft_lane #(
    parameter int WINDOW_LENGTH = fdft_pkg::WINDOW_LENGTH,
    parameter int SAMPLE_WIDTH  = fdft_pkg::SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fdft_pkg::lane_ctrl_t           ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output fdft_pkg::lane_status_t         status
);

    localparam int SW       = SAMPLE_WIDTH;
    localparam int AW       = $clog2(WINDOW_LENGTH);
    localparam int TAP_W    = fdft_pkg::TAP_W;
    localparam int STEP_W   = $clog2(WINDOW_LENGTH + 2);
    localparam int WT_W     = fdft_pkg::WEIGHT_W;
    localparam int PROD_W   = SW + WT_W;
    localparam int ACC_W    = SW + 22;
    localparam int T_W      = ACC_W - fdft_pkg::ROUND_SHIFT;
    localparam int DIV3_BITS = 4;
    localparam int TP_W     = ((T_W + DIV3_BITS - 1) / DIV3_BITS) * DIV3_BITS;
    localparam int DIV3_CYC = TP_W / DIV3_BITS;
    localparam int RE_W     = SW + 8;
    localparam int XP_W     = ((2 * RE_W + 2 + 3) / 4) * 4;
    localparam int MAG_W    = XP_W / 2;
    localparam int SQRT_CYC = MAG_W / 2;
    localparam int KCYC     = MAG_W / 2;
    localparam int KDIV_W   = fdft_pkg::KDIV_W;
    localparam int N_W      = MAG_W + KDIV_W;
    localparam int RMS_W    = fdft_pkg::RMS_W;
    localparam int QX_W     = (MAG_W > RMS_W) ? MAG_W : RMS_W;
    localparam int CNT_W    = $clog2(MAG_W + 1);

    localparam logic [AW-1:0]     LAST_SLOT = AW'(WINDOW_LENGTH - 1);
    localparam logic [STEP_W-1:0] TAP_STEPS = STEP_W'(WINDOW_LENGTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WINDOW_LENGTH + 1);
    localparam logic [2:0]        THREE     = 3'd3;

    typedef enum logic [9:0] {
        L_IDLE = 10'b0000000001,
        L_MAC  = 10'b0000000010,
        L_RND  = 10'b0000000100,
        L_DIV3 = 10'b0000001000,
        L_SQR  = 10'b0000010000,
        L_SUM  = 10'b0000100000,
        L_SQRT = 10'b0001000000,
        L_KLD  = 10'b0010000000,
        L_DIVK = 10'b0100000000,
        L_DONE = 10'b1000000000
    } lane_state_t;

    // control state
    lane_state_t         state_reg, state_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WINDOW_LENGTH-1:0] win_vld_reg, win_vld_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                prd_vld_reg, prd_vld_next;

    // window store and tap pipeline
    logic signed [SW-1:0]     win_mem [WINDOW_LENGTH];
    logic signed [SW-1:0]     rd_data_reg;
    logic [AW-1:0]            rd_k_reg;
    logic signed [PROD_W-1:0] pc_reg, ps_reg;
    logic                     wr_en;

    // arithmetic registers
    logic signed [ACC_W-1:0] acc_c_reg, acc_c_next, acc_s_reg, acc_s_next;
    logic [TP_W-1:0]         t_c_reg, t_c_next, t_s_reg, t_s_next;
    logic [1:0]              r_c_reg, r_c_next, r_s_reg, r_s_next;
    logic [2*RE_W-1:0]       sq_c_reg, sq_c_next, sq_s_reg, sq_s_next;
    logic [XP_W-1:0]         x_reg, x_next;
    logic [MAG_W-1:0]        root_reg, root_next;
    logic [MAG_W+1:0]        srem_reg, srem_next;
    logic [MAG_W-1:0]        kq_reg, kq_next;
    logic [KDIV_W-1:0]       krem_reg, krem_next;

    // combinational helpers
    logic [ACC_W-1:0]  acc_c_abs, acc_s_abs, rnd_c, rnd_s;
    logic [TP_W+1:0]   div3_c, div3_s;
    logic [RE_W-1:0]   re_c, re_s;
    logic [XP_W-1:0]   sq_x;
    logic [MAG_W-1:0]  sq_root;
    logic [MAG_W+1:0]  sq_rem;
    logic [MAG_W+3:0]  sq_rs, sq_trial;
    logic [N_W-1:0]    knum;
    logic [MAG_W-1:0]  kd_q;
    logic [KDIV_W-1:0] kd_rem;
    logic [KDIV_W:0]   kd_r;
    logic [QX_W-1:0]   qx;

    // two-bit remainder divide by three, DIV3_BITS quotient bits per call
    function automatic logic [TP_W+1:0] div3_step(input logic [TP_W-1:0] t, input logic [1:0] r);
        logic [TP_W-1:0] tv;
        logic [1:0]      rv;
        logic [2:0]      v;
        tv = t;
        rv = r;
        for (int i = 0; i < DIV3_BITS; i++)
        begin
            v  = {rv, tv[TP_W-1]};
            tv = {tv[TP_W-2:0], 1'b0};
            if (v >= THREE)
            begin
                rv    = 2'(v - THREE);
                tv[0] = 1'b1;
            end
            else
            begin
                rv = v[1:0];
            end
        end
        return {rv, tv};
    endfunction

    assign wr_en = (state_reg == L_IDLE) && ctrl.start;

    // rounded magnitude of each accumulator, scaled down by 2^10
    assign acc_c_abs = acc_c_reg[ACC_W-1] ? ACC_W'(-acc_c_reg) : ACC_W'(acc_c_reg);
    assign acc_s_abs = acc_s_reg[ACC_W-1] ? ACC_W'(-acc_s_reg) : ACC_W'(acc_s_reg);
    assign rnd_c     = acc_c_abs + ACC_W'(fdft_pkg::ROUND_BIAS);
    assign rnd_s     = acc_s_abs + ACC_W'(fdft_pkg::ROUND_BIAS);

    assign div3_c = div3_step(t_c_reg, r_c_reg);
    assign div3_s = div3_step(t_s_reg, r_s_reg);
    assign re_c   = t_c_reg[RE_W-1:0];
    assign re_s   = t_s_reg[RE_W-1:0];

    // two digit-by-digit square root steps per cycle
    always_comb
    begin
        sq_x    = x_reg;
        sq_root = root_reg;
        sq_rem  = srem_reg;
        sq_rs   = '0;
        sq_trial = '0;
        for (int i = 0; i < 2; i++)
        begin
            sq_rs    = {sq_rem, sq_x[XP_W-1:XP_W-2]};
            sq_x     = {sq_x[XP_W-3:0], 2'b00};
            sq_trial = {2'b00, sq_root, 2'b01};
            if (sq_rs >= sq_trial)
            begin
                sq_rs   = sq_rs - sq_trial;
                sq_root = {sq_root[MAG_W-2:0], 1'b1};
            end
            else
            begin
                sq_root = {sq_root[MAG_W-2:0], 1'b0};
            end
            sq_rem = sq_rs[MAG_W+1:0];
        end
    end

    // two restoring steps of the divide by 1.414 per cycle
    assign knum = {1'b0, root_reg, fdft_pkg::KBIAS};

    always_comb
    begin
        kd_q   = kq_reg;
        kd_rem = krem_reg;
        kd_r   = '0;
        for (int i = 0; i < 2; i++)
        begin
            kd_r = {kd_rem, kd_q[MAG_W-1]};
            kd_q = {kd_q[MAG_W-2:0], 1'b0};
            if (kd_r >= {1'b0, fdft_pkg::KDIV})
            begin
                kd_r    = kd_r - {1'b0, fdft_pkg::KDIV};
                kd_q[0] = 1'b1;
            end
            kd_rem = kd_r[KDIV_W-1:0];
        end
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        addr_next    = addr_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        win_vld_next = win_vld_reg;
        rd_vld_next  = (state_reg == L_MAC) && (step_reg < TAP_STEPS);
        prd_vld_next = rd_vld_reg;
        acc_c_next   = acc_c_reg;
        acc_s_next   = acc_s_reg;
        t_c_next     = t_c_reg;
        t_s_next     = t_s_reg;
        r_c_next     = r_c_reg;
        r_s_next     = r_s_reg;
        sq_c_next    = sq_c_reg;
        sq_s_next    = sq_s_reg;
        x_next       = x_reg;
        root_next    = root_reg;
        srem_next    = srem_reg;
        kq_next      = kq_reg;
        krem_next    = krem_reg;

        case (state_reg)
            L_IDLE:
            begin
                if (ctrl.start)
                begin
                    win_vld_next[slot_reg] = 1'b1;
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    addr_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    step_next  = '0;
                    acc_c_next = '0;
                    acc_s_next = '0;
                    state_next = L_MAC;
                end
            end
            L_MAC:
            begin
                if (step_reg < TAP_STEPS)
                begin
                    addr_next = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                end
                if (prd_vld_reg)
                begin
                    acc_c_next = acc_c_reg + ACC_W'(pc_reg);
                    acc_s_next = acc_s_reg + ACC_W'(ps_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = L_RND;
                end
            end
            L_RND:
            begin
                t_c_next   = TP_W'(rnd_c >> fdft_pkg::ROUND_SHIFT);
                t_s_next   = TP_W'(rnd_s >> fdft_pkg::ROUND_SHIFT);
                r_c_next   = '0;
                r_s_next   = '0;
                cnt_next   = CNT_W'(DIV3_CYC - 1);
                state_next = L_DIV3;
            end
            L_DIV3:
            begin
                {r_c_next, t_c_next} = div3_c;
                {r_s_next, t_s_next} = div3_s;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = L_SQR;
                end
            end
            L_SQR:
            begin
                sq_c_next  = re_c * re_c;
                sq_s_next  = re_s * re_s;
                state_next = L_SUM;
            end
            L_SUM:
            begin
                x_next     = XP_W'(sq_c_reg) + XP_W'(sq_s_reg);
                root_next  = '0;
                srem_next  = '0;
                cnt_next   = CNT_W'(SQRT_CYC - 1);
                state_next = L_SQRT;
            end
            L_SQRT:
            begin
                x_next    = sq_x;
                root_next = sq_root;
                srem_next = sq_rem;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = L_KLD;
                end
            end
            L_KLD:
            begin
                kq_next    = knum[MAG_W-1:0];
                krem_next  = knum[N_W-1:MAG_W];
                cnt_next   = CNT_W'(KCYC - 1);
                state_next = L_DIVK;
            end
            L_DIVK:
            begin
                kq_next   = kd_q;
                krem_next = kd_rem;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= L_IDLE;
            slot_reg    <= '0;
            addr_reg    <= '0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            win_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            prd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            addr_reg    <= addr_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            win_vld_reg <= win_vld_next;
            rd_vld_reg  <= rd_vld_next;
            prd_vld_reg <= prd_vld_next;
        end
    end

    // window store: one write port, one registered read port; unwritten slots read as zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[slot_reg] <= sample;
        end
        rd_data_reg <= win_vld_reg[addr_reg] ? win_mem[addr_reg] : '0;
        rd_k_reg    <= step_reg[AW-1:0];
    end

    // tap products and arithmetic payload
    always_ff @(posedge clk)
    begin
        pc_reg    <= rd_data_reg * fdft_pkg::cos_weight(TAP_W'(rd_k_reg));
        ps_reg    <= rd_data_reg * fdft_pkg::sin_weight(TAP_W'(rd_k_reg));
        acc_c_reg <= acc_c_next;
        acc_s_reg <= acc_s_next;
        t_c_reg   <= t_c_next;
        t_s_reg   <= t_s_next;
        r_c_reg   <= r_c_next;
        r_s_reg   <= r_s_next;
        sq_c_reg  <= sq_c_next;
        sq_s_reg  <= sq_s_next;
        x_reg     <= x_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        kq_reg    <= kq_next;
        krem_reg  <= krem_next;
    end

    // saturated result towards the merge stage
    assign qx          = QX_W'(kq_reg);
    assign status.done = (state_reg == L_DONE);
    assign status.rms  = (qx > QX_W'(fdft_pkg::RMS_MAX)) ? fdft_pkg::RMS_MAX : qx[RMS_W-1:0];

endmodule

/* rtl/fdft_merge.sv */
// Merge stage: joins both lane results into one output transaction held in a register.
`timescale 1ns / 1ps

module fdft_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fdft_pkg::lane_status_t stat0,
    input  fdft_pkg::lane_status_t stat1,
    fdft_out_if.source             levels,
    output logic                   ack
);

    logic                       out_valid_reg, out_valid_next;
    logic [fdft_pkg::RMS_W-1:0] c0_reg, c1_reg;
    logic                       load;

    // load when both lanes are finished and the output slot is free or draining
    assign load = stat0.done && stat1.done && (!out_valid_reg || levels.ready);
    assign ack  = load;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (levels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c0_reg <= stat0.rms;
            c1_reg <= stat1.rms;
        end
    end

    assign levels.valid     = out_valid_reg;
    assign levels.chan0_rms = c0_reg;
    assign levels.chan1_rms = c1_reg;

endmodule

/* rtl/fundamental_rms_dft24_top.sv */
// Top level of the two-channel 24-point fundamental RMS meter.
// One sample pair is in flight at a time: a new pair is taken only once the previous result
// is loaded into the output register, as set by the serial walk over the 24 taps and the
// digit-serial divide, square root and scaling units of each lane.
// Reset clears both windows (per-slot valid bits) and the write slot at once; no sweep.
`timescale 1ns / 1ps

module fundamental_rms_dft24_top #(
    parameter int WINDOW_LENGTH = fdft_pkg::WINDOW_LENGTH,
    parameter int SAMPLE_WIDTH  = fdft_pkg::SAMPLE_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    fdft_in_if.sink    samples,
    fdft_out_if.source levels
);

    logic                   busy_reg, busy_next;
    logic                   accept;
    logic                   ack;
    fdft_pkg::lane_ctrl_t   ctrl;
    fdft_pkg::lane_status_t stat0, stat1;

    // one sample pair in flight at a time
    assign samples.ready = !busy_reg;
    assign accept        = samples.valid && !busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (ack)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign ctrl.start = accept;
    assign ctrl.ack   = ack;

    // one lane per channel
    fdft_lane #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_lane0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (samples.chan0_sample),
        .status (stat0)
    );

    fdft_lane #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_lane1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (samples.chan1_sample),
        .status (stat1)
    );

    fdft_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat0  (stat0),
        .stat1  (stat1),
        .levels (levels),
        .ack    (ack)
    );

endmodule

/* rtl/fdft_checker.sv */
// Port-level assertions for the fundamental RMS meter, bound to the top level.
`timescale 1ns / 1ps

module fdft_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [fdft_pkg::RMS_W-1:0] out_c0,
    input logic [fdft_pkg::RMS_W-1:0] out_c1
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its values
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_c0) && $stable(out_c1))
        else $error("result changed while stalled");

    // an accepted sample pair blocks the input until its result is loaded
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample pair is in flight");

    // loading a new result frees the input side in the same cycle
    a_free_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input still blocked after result load");

endmodule

bind fundamental_rms_dft24_top fdft_checker u_fdft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .out_c0    (levels.chan0_rms),
    .out_c1    (levels.chan1_rms)
);

/* dv/fundamental_rms_dft24_top_test.sv */
// Self-checking testbench for the two-channel 24-point fundamental RMS meter.
`timescale 1ns / 1ps

module fundamental_rms_dft24_top_test;

    import fdft_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t sample_hist_t [WINDOW_LENGTH];

    typedef struct packed {
        logic [RMS_W-1:0] chan0_rms;
        logic [RMS_W-1:0] chan1_rms;
    } rms_pair_t;

    typedef enum int {
        BURST_UNIFORM,
        BURST_SINE,
        BURST_SQUARE,
        BURST_SMALL,
        BURST_DC
    } burst_kind_t;

    localparam sample_t SAMPLE_MAX   = 16'sh7fff;
    localparam sample_t SAMPLE_MIN   = 16'sh8000;
    localparam int      RANDOM_ITEMS = 1570;
    localparam int      LONG_HOLD    = 800;
    localparam int      DRAIN_CYCLES = 80;
    localparam int      SHOW_LIMIT   = 10;
    localparam real     TWO_PI       = 6.283185307179586;

    logic clk;
    logic rst_n;

    fdft_in_if  samples_if ();
    fdft_out_if levels_if ();

    fundamental_rms_dft24_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .levels  (levels_if)
    );

    // predictor state: mirror of both sample windows and the write pointer
    sample_hist_t hist_chan0;
    sample_hist_t hist_chan1;
    int           write_ptr;

    rms_pair_t pending_levels [$];

    int  failures;
    int  items_sent;
    int  levels_checked;
    bit  quiet_mode;
    bit  hold_request;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Level predictor
    // ---------------------------------------------------------------

    // Q1.16 fold weights: cos 15, 30, 45, 60, 75 degrees, and 1.0 (cos 0) for any other index
    function automatic longint fold_weight(input int idx);
        case (idx)
            0:       return 63303;
            1:       return 56754;
            2:       return 46341;
            3:       return 32768;
            4:       return 16962;
            default: return 65536;
        endcase
    endfunction

    // divide by 12 * 2^16 / 2^8, rounding half away from zero
    function automatic longint scale_to_q8(input longint acc);
        longint m;
        m = (acc < 0) ? -acc : acc;
        m = (m + 1536) / 3072;
        return (acc < 0) ? -m : m;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (x >= root + probe)
            begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // fundamental RMS of one window, oldest sample at slot 'start'
    function automatic logic [RMS_W-1:0] fundamental_level(input sample_hist_t h,
                                                           input int start);
        longint          s [WINDOW_LENGTH];
        longint          fold_re [6];
        longint          fold_im [6];
        longint          acc_re;
        longint          acc_im;
        longint          part_re;
        longint          part_im;
        longint unsigned abs_re;
        longint unsigned abs_im;
        longint unsigned mag;
        longint unsigned level;
        for (int i = 0; i < WINDOW_LENGTH; i++)
            s[i] = h[(start + i) % WINDOW_LENGTH];
        // quarter-wave folding of the 24 taps
        for (int i = 1; i <= 5; i++)
        begin
            fold_re[i-1] = s[i] + s[24-i] - s[12-i] - s[12+i];
            fold_im[i-1] = s[i] + s[12-i] - s[12+i] - s[24-i];
        end
        fold_re[5] = s[0] - s[12];
        fold_im[5] = s[6] - s[18];
        acc_re = 0;
        acc_im = 0;
        for (int i = 0; i < 5; i++)
        begin
            acc_re += fold_re[i] * fold_weight(i);
            acc_im += fold_im[i] * fold_weight(4 - i);
        end
        acc_re += fold_re[5] * fold_weight(5);
        acc_im += fold_im[5] * fold_weight(5);
        part_re = scale_to_q8(acc_re);
        part_im = scale_to_q8(acc_im);
        abs_re  = (part_re < 0) ? -part_re : part_re;
        abs_im  = (part_im < 0) ? -part_im : part_im;
        mag     = int_sqrt(abs_re * abs_re + abs_im * abs_im);
        // divide by 1.414 in Q16, rounded
        level   = (mag * 65536 + 46334) / 92668;
        if (level > RMS_MAX)
            level = RMS_MAX;
        return level[RMS_W-1:0];
    endfunction

    // store one accepted sample pair and queue the expected levels
    task automatic predict_levels(input sample_t s0, input sample_t s1);
        int        slot;
        rms_pair_t lv;
        slot = (write_ptr < WINDOW_LENGTH) ? write_ptr : 0;
        hist_chan0[slot] = s0;
        hist_chan1[slot] = s1;
        write_ptr = (slot + 1) % WINDOW_LENGTH;
        lv.chan0_rms = fundamental_level(hist_chan0, write_ptr);
        lv.chan1_rms = fundamental_level(hist_chan1, write_ptr);
        pending_levels.push_back(lv);
    endtask

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    function automatic sample_t to_sample(input real v);
        if (v > 32767.0)
            return SAMPLE_MAX;
        if (v < -32768.0)
            return SAMPLE_MIN;
        return $rtoi(v);
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= SHOW_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // offer one sample pair and wait for the transaction
    task automatic send_pair(input sample_t s0, input sample_t s1);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid        <= 1'b1;
        samples_if.chan0_sample <= s0;
        samples_if.chan1_sample <= s1;
        do
            @(posedge clk);
        while (!samples_if.ready);
        predict_levels(s0, s1);
        items_sent++;
    endtask

    // ---------------------------------------------------------------
    // Result sink: random back-pressure and checking
    // ---------------------------------------------------------------
    initial
    begin
        int        stall_left;
        bit        hold_seen;
        rms_pair_t exp_lv;
        stall_left = 0;
        hold_seen  = 1'b0;
        levels_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (levels_if.valid && levels_if.ready)
            begin
                levels_checked++;
                if (pending_levels.size() == 0)
                begin
                    note_failure($sformatf("unexpected result ch0=%0d ch1=%0d",
                                           levels_if.chan0_rms, levels_if.chan1_rms));
                end
                else
                begin
                    exp_lv = pending_levels.pop_front();
                    if (levels_if.chan0_rms !== exp_lv.chan0_rms)
                        note_failure($sformatf("chan0_rms expected %0d actual %0d",
                                               exp_lv.chan0_rms, levels_if.chan0_rms));
                    if (levels_if.chan1_rms !== exp_lv.chan1_rms)
                        note_failure($sformatf("chan1_rms expected %0d actual %0d",
                                               exp_lv.chan1_rms, levels_if.chan1_rms));
                end
            end
            // long hold-off on request, otherwise random stalls
            if (hold_request && !hold_seen)
                stall_left = LONG_HOLD;
            hold_seen = hold_request;
            if (stall_left > 0)
            begin
                levels_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                levels_if.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // partly filled window straight after reset, field extremes and bit patterns
    task automatic test_startup_extremes();
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sh5555, 16'shaaaa);
        send_pair(16'shaaaa, 16'sh5555);
        send_pair(16'sd1, -16'sd1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
    endtask

    // full-scale half-period square on both channels, in anti-phase
    task automatic test_full_scale_square();
        for (int n = 0; n < 12; n++)
        begin
            if (n < 6)
                send_pair(SAMPLE_MAX, SAMPLE_MIN);
            else
                send_pair(SAMPLE_MIN, SAMPLE_MAX);
        end
    endtask

    // output held off for a long stretch while sample pairs keep being offered
    task automatic test_output_hold();
        quiet_mode   <= 1'b1;
        hold_request <= 1'b1;
        for (int n = 0; n < 14; n++)
            send_pair($urandom, $urandom);
        hold_request <= 1'b0;
        quiet_mode   <= 1'b0;
    endtask

    // bursts of waveforms with random content
    task automatic test_random_bursts();
        burst_kind_t kind;
        int          len;
        int          harm;
        real         amp0;
        real         amp1;
        real         ph0;
        real         ph1;
        real         ang;
        sample_t     s0;
        sample_t     s1;
        sample_t     hi;
        sample_t     lo;
        int          done_items;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            kind = burst_kind_t'($urandom_range(0, 4));
            len  = $urandom_range(24, 72);
            quiet_mode <= ($urandom_range(0, 5) == 0);
            harm = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 4);
            amp0 = $urandom_range(0, 33000);
            amp1 = $urandom_range(0, 33000);
            ph0  = TWO_PI * $urandom_range(0, 359) / 360.0;
            ph1  = TWO_PI * $urandom_range(0, 359) / 360.0;
            hi   = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : sample_t'($urandom);
            lo   = ($urandom_range(0, 1) == 1) ? SAMPLE_MIN : sample_t'($urandom);
            s0   = $urandom;
            s1   = $urandom;
            for (int n = 0; n < len; n++)
            begin
                case (kind)
                    BURST_UNIFORM:
                    begin
                        s0 = $urandom;
                        s1 = $urandom;
                    end
                    BURST_SINE:
                    begin
                        ang = TWO_PI * harm * n / 24.0;
                        s0  = to_sample(amp0 * $sin(ang + ph0) + $urandom_range(0, 8) - 4.0);
                        s1  = to_sample(amp1 * $sin(ang + ph1) + $urandom_range(0, 8) - 4.0);
                    end
                    BURST_SQUARE:
                    begin
                        s0 = ((n % 24) < 12) ? hi : lo;
                        s1 = ((n % 24) < 12) ? lo : hi;
                    end
                    BURST_SMALL:
                    begin
                        s0 = $urandom_range(0, 8) - 4;
                        s1 = $urandom_range(0, 8) - 4;
                    end
                    default:
                    begin
                        // steady level with the odd one-count step
                        if ($urandom_range(0, 15) == 0)
                            s0 = s0 + 1;
                        if ($urandom_range(0, 15) == 0)
                            s1 = s1 - 1;
                    end
                endcase
                send_pair(s0, s1);
                done_items++;
            end
        end
        quiet_mode <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        failures       = 0;
        items_sent     = 0;
        levels_checked = 0;
        write_ptr      = 0;
        for (int i = 0; i < WINDOW_LENGTH; i++)
        begin
            hist_chan0[i] = '0;
            hist_chan1[i] = '0;
        end
        quiet_mode              <= 1'b0;
        hold_request            <= 1'b0;
        rst_n                   <= 1'b0;
        samples_if.valid        <= 1'b0;
        samples_if.chan0_sample <= '0;
        samples_if.chan1_sample <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_extremes();
        test_full_scale_square();
        test_output_hold();
        test_random_bursts();

        samples_if.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered start-up window, full-scale extremes, sine/square/DC/small bursts");
        $display("and a long output hold: %0d sample pairs sent, %0d level pairs checked.",
                 items_sent, levels_checked);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
